>>> hw/rtl/crcfr_pkg.sv
// Package: shared types, constants and CRC step functions for the CRC forward/reverse patch block.
`default_nettype none
package crcfr_pkg;

  localparam int unsigned MaxWidthBytes = 8;
  localparam int unsigned CrcW          = 8 * MaxWidthBytes;
  localparam int unsigned ShW           = $clog2(CrcW);
  localparam int unsigned ActW          = 3;
  localparam int unsigned CfgIdxW       = 3;

  localparam logic [ActW-1:0] ActStart = 3'd0;
  localparam logic [ActW-1:0] ActFwd   = 3'd1;
  localparam logic [ActW-1:0] ActRev   = 3'd2;
  localparam logic [ActW-1:0] ActRead  = 3'd3;
  localparam logic [ActW-1:0] ActPatch = 3'd4;

  localparam logic [CfgIdxW-1:0] CfgPoly  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgWidth = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgMsb   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgInit  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgFinal = 3'd4;

  localparam logic [CrcW-1:0] PolyRst  = 64'h0000_0000_04C1_1DB7;
  localparam logic [3:0]      WidthRst = 4'd4;
  localparam logic [CrcW-1:0] InitRst  = 64'h0000_0000_FFFF_FFFF;
  localparam logic [CrcW-1:0] FinalRst = 64'h0000_0000_FFFF_FFFF;

  typedef enum logic [2:0] {
    OpStart,
    OpFwd,
    OpRev,
    OpRead,
    OpPatch,
    OpNone
  } op_e;

  typedef struct packed {
    logic            msb;
    logic [3:0]      nb;
    logic [ShW-1:0]  sh;
    logic [CrcW-1:0] mask;
    logic [CrcW-1:0] top;
    logic [CrcW-1:0] poly_m;
    logic [CrcW-1:0] poly_a;
    logic [CrcW-1:0] poly_r;
    logic [CrcW-1:0] init_x;
    logic [CrcW-1:0] final_x;
  } cfg_t;

  typedef struct packed {
    op_e             op;
    logic [7:0]      data;
    logic [CrcW-1:0] seed;
  } cmd_t;

  function automatic logic [3:0] clamp_nb(logic [3:0] wb);
    logic [3:0] n;
    n = wb;
    if (n == 4'd0) n = 4'd1;
    if (n > 4'(MaxWidthBytes)) n = 4'(MaxWidthBytes);
    return n;
  endfunction

  function automatic logic [ShW-1:0] shift_of(logic [3:0] nb);
    return ShW'((int'(MaxWidthBytes) - int'(nb)) * 8);
  endfunction

  function automatic logic [CrcW-1:0] byte_swap(logic [CrcW-1:0] x, logic [ShW-1:0] sh);
    logic [CrcW-1:0] r;
    for (int i = 0; i < int'(MaxWidthBytes); i++) begin
      r[8*(int'(MaxWidthBytes)-1-i) +: 8] = x[8*i +: 8];
    end
    return r >> sh;
  endfunction

  function automatic logic [CrcW-1:0] fwd_step(logic [CrcW-1:0] crc, logic [7:0] c, cfg_t cfg);
    logic [CrcW-1:0] a;
    if (cfg.msb) begin
      a = ((crc & cfg.mask) << cfg.sh) ^ {c, {(CrcW-8){1'b0}}};
      for (int k = 0; k < 8; k++) begin
        a = a[CrcW-1] ? ((a << 1) ^ cfg.poly_a) : (a << 1);
      end
      a = a >> cfg.sh;
    end else begin
      a = (crc & cfg.mask) ^ {{(CrcW-8){1'b0}}, c};
      for (int k = 0; k < 8; k++) begin
        a = a[0] ? ((a >> 1) ^ cfg.poly_r) : (a >> 1);
      end
    end
    return a & cfg.mask;
  endfunction

  function automatic logic [CrcW-1:0] back_step(logic [CrcW-1:0] crc, logic [7:0] c, cfg_t cfg);
    logic [CrcW-1:0] a;
    a = crc & cfg.mask;
    if (cfg.msb) begin
      for (int k = 0; k < 8; k++) begin
        a = a[0] ? (((a ^ cfg.poly_m) >> 1) | cfg.top) : (a >> 1);
      end
      a = a ^ ({c, {(CrcW-8){1'b0}}} >> cfg.sh);
    end else begin
      for (int k = 0; k < 8; k++) begin
        a = ((a & cfg.top) != '0) ? ((((a ^ cfg.poly_r) << 1) | CrcW'(1)) & cfg.mask)
                                  : ((a << 1) & cfg.mask);
      end
      a = a ^ {{(CrcW-8){1'b0}}, c};
    end
    return a & cfg.mask;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/crcfr_if.sv
// Interfaces: request and result channels with valid/ready handshake.
`default_nettype none
interface crcfr_in_if;
  import crcfr_pkg::*;
  logic            valid;
  logic            ready;
  logic [ActW-1:0] action;
  logic [7:0]      data_byte;
  logic [CrcW-1:0] target_value;

  modport source (output valid, action, data_byte, target_value, input ready);
  modport sink   (input valid, action, data_byte, target_value, output ready);
endinterface

interface crcfr_out_if;
  import crcfr_pkg::*;
  logic            valid;
  logic            ready;
  logic [CrcW-1:0] result_value;

  modport source (output valid, result_value, input ready);
  modport sink   (input valid, result_value, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/crcfr_cfg.sv
// Configuration registers and derived width, mask and polynomial forms.
`default_nettype none
module crcfr_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [crcfr_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [crcfr_pkg::CrcW-1:0]        cfg_data_i,
  output crcfr_pkg::cfg_t                   cfg_o
);
  import crcfr_pkg::*;

  logic [CrcW-1:0] poly_q;
  logic [3:0]      wb_q;
  logic            msb_q;
  logic [CrcW-1:0] init_q;
  logic [CrcW-1:0] final_q;
  logic [CrcW-1:0] poly_rev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q  <= PolyRst;
      wb_q    <= WidthRst;
      msb_q   <= 1'b0;
      init_q  <= InitRst;
      final_q <= FinalRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgPoly:  poly_q  <= cfg_data_i;
        CfgWidth: wb_q    <= cfg_data_i[3:0];
        CfgMsb:   msb_q   <= cfg_data_i[0];
        CfgInit:  init_q  <= cfg_data_i;
        CfgFinal: final_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < int'(CrcW); i++) begin
      poly_rev[CrcW-1-i] = poly_q[i];
    end
  end

  always_comb begin
    cfg_o.msb     = msb_q;
    cfg_o.nb      = clamp_nb(wb_q);
    cfg_o.sh      = shift_of(cfg_o.nb);
    cfg_o.mask    = {CrcW{1'b1}} >> cfg_o.sh;
    cfg_o.top     = {1'b1, {(CrcW-1){1'b0}}} >> cfg_o.sh;
    cfg_o.poly_m  = poly_q & cfg_o.mask;
    cfg_o.poly_a  = cfg_o.poly_m << cfg_o.sh;
    cfg_o.poly_r  = poly_rev >> cfg_o.sh;
    cfg_o.init_x  = init_q;
    cfg_o.final_x = final_q;
  end
endmodule
`default_nettype wire

>>> hw/rtl/crcfr_front.sv
// Front end: accepts request transactions, decodes the action and prepares the reverse seed.
`default_nettype none
module crcfr_front (
  crcfr_in_if.sink          in_if,
  input  crcfr_pkg::cfg_t   cfg_i,
  input  logic              full_i,
  output logic              push_o,
  output crcfr_pkg::cmd_t   cmd_o
);
  import crcfr_pkg::*;

  assign in_if.ready = !full_i;
  assign push_o      = in_if.valid && !full_i;

  always_comb begin
    unique case (in_if.action)
      ActStart: cmd_o.op = OpStart;
      ActFwd:   cmd_o.op = OpFwd;
      ActRev:   cmd_o.op = OpRev;
      ActRead:  cmd_o.op = OpRead;
      ActPatch: cmd_o.op = OpPatch;
      default:  cmd_o.op = OpNone;
    endcase
    cmd_o.data = in_if.data_byte;
    cmd_o.seed = (in_if.target_value ^ cfg_i.final_x) & cfg_i.mask;
  end
endmodule
`default_nettype wire

>>> hw/rtl/crcfr_queue.sv
// Command queue between front and back end.
`default_nettype none
module crcfr_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  crcfr_pkg::cmd_t   cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output crcfr_pkg::cmd_t   cmd_o
);
  import crcfr_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q;
  logic [PtrW-1:0] rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/crcfr_back.sv
// Back end: forward/reverse CRC registers, iterative patch unit and result register.
`default_nettype none
module crcfr_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  crcfr_pkg::cfg_t   cfg_i,
  input  logic              empty_i,
  input  crcfr_pkg::cmd_t   cmd_i,
  output logic              pop_o,
  crcfr_out_if.source       out_if
);
  import crcfr_pkg::*;

  logic [CrcW-1:0] fwd_q;
  logic [CrcW-1:0] rev_q;
  logic            busy_q;
  logic [2:0]      cnt_q;
  logic [CrcW-1:0] acc_q;
  logic [CrcW-1:0] head_q;
  logic            out_valid_q;
  logic [CrcW-1:0] out_data_q;

  logic            slot_free;
  logic [CrcW-1:0] fwd_nx;
  logic [CrcW-1:0] rev_nx;
  logic [CrcW-1:0] res;
  logic [2:0]      idx;
  logic [2:0]      last_cnt;
  logic            last;
  logic [CrcW-1:0] acc_nx;
  logic            step_en;

  assign slot_free = !out_valid_q || out_if.ready;
  assign pop_o     = !empty_i && !busy_q && slot_free;

  always_comb begin
    fwd_nx = fwd_q;
    rev_nx = rev_q;
    res    = '0;
    unique case (cmd_i.op)
      OpStart: begin
        fwd_nx = cfg_i.init_x & cfg_i.mask;
        rev_nx = cmd_i.seed;
        res    = fwd_nx;
      end
      OpFwd: begin
        fwd_nx = fwd_step(fwd_q, cmd_i.data, cfg_i);
        res    = fwd_nx;
      end
      OpRev: begin
        rev_nx = back_step(rev_q, cmd_i.data, cfg_i);
        res    = rev_nx;
      end
      OpRead:  res = (fwd_q ^ cfg_i.final_x) & cfg_i.mask;
      OpPatch: res = '0;
      OpNone:  res = '0;
      default: res = '0;
    endcase
  end

  // patch: step i takes head byte i, from the low end if msb, else the high end
  assign last_cnt = 3'(cfg_i.nb - 4'd1);
  assign idx      = cfg_i.msb ? cnt_q : (last_cnt - cnt_q);
  assign last     = (cnt_q == last_cnt);
  assign acc_nx   = back_step(acc_q, head_q[{idx, 3'b000} +: 8], cfg_i);
  assign step_en  = busy_q && (!last || slot_free);

  always_ff @(posedge clk_i) begin
    if (pop_o && cmd_i.op == OpPatch) begin
      acc_q  <= rev_q & cfg_i.mask;
      head_q <= fwd_q & cfg_i.mask;
    end else if (step_en) begin
      acc_q <= acc_nx;
    end
    if (pop_o && cmd_i.op != OpPatch) begin
      out_data_q <= res;
    end else if (step_en && last) begin
      out_data_q <= cfg_i.msb ? byte_swap(acc_nx, cfg_i.sh) : acc_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q       <= InitRst;
      rev_q       <= '0;
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o) begin
        fwd_q <= fwd_nx;
        rev_q <= rev_nx;
        if (cmd_i.op == OpPatch) begin
          busy_q <= 1'b1;
          cnt_q  <= '0;
        end else begin
          out_valid_q <= 1'b1;
        end
      end
      if (step_en) begin
        cnt_q <= cnt_q + 3'd1;
        if (last) begin
          busy_q      <= 1'b0;
          out_valid_q <= 1'b1;
        end
      end
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.result_value = out_data_q;
endmodule
`default_nettype wire

>>> hw/rtl/crc_forward_reverse_patch.sv
// Top level: CRC engine with forward and reverse registers and patch computation.
//
//   channel   dir   handshake     payload
//   in_if     in    valid/ready   action, data_byte, target_value
//   out_if    out   valid/ready   result_value
//   cfg       in    cfg_we_i      cfg_idx_i, cfg_data_i (write only)
//
// Start, forward, reverse, read and unused codes: one transaction per cycle in the
// back end while no patch runs and the result slot is free; the result is valid in
// the cycle after the back end takes the command. Compute patch loads the unit, then
// does one backward byte step per cycle over nb bytes, the last waiting for a free slot.
// Reset is asynchronous; configuration resets to reflected CRC-32.
// A command queue and the result register decouple the two sides on stalls.
`default_nettype none
module crc_forward_reverse_patch #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [crcfr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [crcfr_pkg::CrcW-1:0]     cfg_data_i,
  crcfr_in_if.sink                       in_if,
  crcfr_out_if.source                    out_if
);
  import crcfr_pkg::*;

  cfg_t cfg;
  cmd_t push_cmd;
  cmd_t head_cmd;
  logic push;
  logic full;
  logic pop;
  logic empty;

  crcfr_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  crcfr_front u_front (
    .in_if  (in_if),
    .cfg_i  (cfg),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  crcfr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cmd_o   (head_cmd)
  );

  crcfr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .empty_i (empty),
    .cmd_i   (head_cmd),
    .pop_o   (pop),
    .out_if  (out_if)
  );
endmodule
`default_nettype wire

>>> hw/rtl/crcfr_checker.sv
// Checker: port-level assertions for the CRC patch block, bound to the top level.
`default_nettype none
module crcfr_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic [crcfr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input logic [crcfr_pkg::CrcW-1:0]     cfg_data_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [crcfr_pkg::CrcW-1:0]     out_result_i
);
  import crcfr_pkg::*;

  logic [3:0]      wb_q;
  logic [CrcW-1:0] width_mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_q <= WidthRst;
    end else if (cfg_we_i && cfg_idx_i == CfgWidth) begin
      wb_q <= cfg_data_i[3:0];
    end
  end

  assign width_mask = {CrcW{1'b1}} >> shift_of(clamp_nb(wb_q));

  a_no_result_in_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_result_i))
    else $error("stalled result dropped or changed");

  a_result_in_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_result_i & ~width_mask) == '0)
    else $error("result wider than configured CRC width");
endmodule

bind crc_forward_reverse_patch crcfr_checker u_crcfr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cfg_we_i     (cfg_we_i),
  .cfg_idx_i    (cfg_idx_i),
  .cfg_data_i   (cfg_data_i),
  .out_valid_i  (out_if.valid),
  .out_ready_i  (out_if.ready),
  .out_result_i (out_if.result_value)
);
`default_nettype wire
